// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the segment test pipeline
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next cycle check failed");

`endif

// ===== rtl/core/segx_pkg.sv =====
// types and constants for the segment intersection test pipeline
// no dependencies
package segx_pkg;

   // orientation sign of one cross product comparison
   typedef enum logic [1:0] {
      ORIENT_ZERO,
      ORIENT_POS,
      ORIENT_NEG
   } orient_type;

   // endpoint inside the bounding box of the other segment
   typedef struct packed {
      logic c_in_ab;
      logic d_in_ab;
      logic a_in_cd;
      logic b_in_cd;
   } box_flags_type;

   typedef struct packed {
      orient_type o1;
      orient_type o2;
      orient_type o3;
      orient_type o4;
   } orient_set_type;

   // places of the coordinate differences in the difference vector
   localparam int DIFF_COUNT = 12;
   localparam int DIFF_BAX   = 0;
   localparam int DIFF_BAY   = 1;
   localparam int DIFF_CAX   = 2;
   localparam int DIFF_CAY   = 3;
   localparam int DIFF_DAX   = 4;
   localparam int DIFF_DAY   = 5;
   localparam int DIFF_DCX   = 6;
   localparam int DIFF_DCY   = 7;
   localparam int DIFF_ACX   = 8;
   localparam int DIFF_ACY   = 9;
   localparam int DIFF_BCX   = 10;
   localparam int DIFF_BCY   = 11;

   localparam int ORIENT_COUNT = 4;

endpackage

// ===== rtl/core/segx_req_if.sv =====
// request channel carrying one segment pair per transfer
// no dependencies
interface segx_req_if #(
   parameter int COORD_WIDTH = 31
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] seg1_ax;
   logic signed [COORD_WIDTH-1:0] seg1_ay;
   logic signed [COORD_WIDTH-1:0] seg1_bx;
   logic signed [COORD_WIDTH-1:0] seg1_by;
   logic signed [COORD_WIDTH-1:0] seg2_ax;
   logic signed [COORD_WIDTH-1:0] seg2_ay;
   logic signed [COORD_WIDTH-1:0] seg2_bx;
   logic signed [COORD_WIDTH-1:0] seg2_by;

   modport source (
      output valid, seg1_ax, seg1_ay, seg1_bx, seg1_by,
             seg2_ax, seg2_ay, seg2_bx, seg2_by,
      input  ready
   );

   modport sink (
      input  valid, seg1_ax, seg1_ay, seg1_bx, seg1_by,
             seg2_ax, seg2_ay, seg2_bx, seg2_by,
      output ready
   );
endinterface

// ===== rtl/core/segx_rsp_if.sv =====
// response channel carrying one intersection flag per transfer
// no dependencies
interface segx_rsp_if;
   logic valid;
   logic ready;
   logic intersects;

   modport source (
      output valid, intersects,
      input  ready
   );

   modport sink (
      input  valid, intersects,
      output ready
   );
endinterface

// ===== rtl/core/segx_diff_stage.sv =====
// first stage: coordinate differences and bounding box checks
// depends on segx_pkg and assert_macros.svh
`include "assert_macros.svh"

module segx_diff_stage
   import segx_pkg::*;
#(
   parameter int COORD_WIDTH = 31,
   localparam int DiffWidth = COORD_WIDTH + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   output logic                          ready_up,
   input  logic signed [COORD_WIDTH-1:0] ax,
   input  logic signed [COORD_WIDTH-1:0] ay,
   input  logic signed [COORD_WIDTH-1:0] bx,
   input  logic signed [COORD_WIDTH-1:0] by,
   input  logic signed [COORD_WIDTH-1:0] cx,
   input  logic signed [COORD_WIDTH-1:0] cy,
   input  logic signed [COORD_WIDTH-1:0] dx,
   input  logic signed [COORD_WIDTH-1:0] dy,
   output logic                          valid_out,
   input  logic                          ready_down,
   output logic signed [DiffWidth-1:0]   diff_out [DIFF_COUNT],
   output box_flags_type                 box_out
);

   logic                        valid_ff;
   logic signed [DiffWidth-1:0] diff_ff [DIFF_COUNT];
   logic signed [DiffWidth-1:0] diff_in [DIFF_COUNT];
   box_flags_type               box_ff;
   box_flags_type               box_in;
   logic                        load;

   function automatic logic in_box(
      input logic signed [COORD_WIDTH-1:0] px,
      input logic signed [COORD_WIDTH-1:0] py,
      input logic signed [COORD_WIDTH-1:0] qx,
      input logic signed [COORD_WIDTH-1:0] qy,
      input logic signed [COORD_WIDTH-1:0] rx,
      input logic signed [COORD_WIDTH-1:0] ry
   );
      logic x_ok;
      logic y_ok;
      x_ok = ((rx >= px) && (rx <= qx)) || ((rx >= qx) && (rx <= px));
      y_ok = ((ry >= py) && (ry <= qy)) || ((ry >= qy) && (ry <= py));
      return x_ok && y_ok;
   endfunction

   always_comb begin
      diff_in[DIFF_BAX] = DiffWidth'(bx) - DiffWidth'(ax);
      diff_in[DIFF_BAY] = DiffWidth'(by) - DiffWidth'(ay);
      diff_in[DIFF_CAX] = DiffWidth'(cx) - DiffWidth'(ax);
      diff_in[DIFF_CAY] = DiffWidth'(cy) - DiffWidth'(ay);
      diff_in[DIFF_DAX] = DiffWidth'(dx) - DiffWidth'(ax);
      diff_in[DIFF_DAY] = DiffWidth'(dy) - DiffWidth'(ay);
      diff_in[DIFF_DCX] = DiffWidth'(dx) - DiffWidth'(cx);
      diff_in[DIFF_DCY] = DiffWidth'(dy) - DiffWidth'(cy);
      diff_in[DIFF_ACX] = DiffWidth'(ax) - DiffWidth'(cx);
      diff_in[DIFF_ACY] = DiffWidth'(ay) - DiffWidth'(cy);
      diff_in[DIFF_BCX] = DiffWidth'(bx) - DiffWidth'(cx);
      diff_in[DIFF_BCY] = DiffWidth'(by) - DiffWidth'(cy);
      box_in.c_in_ab = in_box(ax, ay, bx, by, cx, cy);
      box_in.d_in_ab = in_box(ax, ay, bx, by, dx, dy);
      box_in.a_in_cd = in_box(cx, cy, dx, dy, ax, ay);
      box_in.b_in_cd = in_box(cx, cy, dx, dy, bx, by);
   end

   assign ready_up = !valid_ff || ready_down;
   assign load     = valid_in && ready_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_in;
      end
      if (load) begin
         diff_ff <= diff_in;
         box_ff  <= box_in;
      end
   end

   assign valid_out = valid_ff;
   assign diff_out  = diff_ff;
   assign box_out   = box_ff;

   // a first endpoint shared by both segments (a equal to c) always lies in the other box
   `ASSERT_SAME(shared_end_in_box,
      valid_ff && (diff_ff[DIFF_CAX] == '0) && (diff_ff[DIFF_CAY] == '0),
      box_ff.c_in_ab && box_ff.a_in_cd)

endmodule

// ===== rtl/core/segx_orient_stage.sv =====
// second and third stages: cross products, then orientation signs
// depends on segx_pkg and assert_macros.svh
`include "assert_macros.svh"

module segx_orient_stage
   import segx_pkg::*;
#(
   parameter int COORD_WIDTH = 31,
   localparam int DiffWidth = COORD_WIDTH + 1,
   localparam int ProdWidth = 2 * DiffWidth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid_in,
   output logic                        ready_up,
   input  logic signed [DiffWidth-1:0] diff_in [DIFF_COUNT],
   input  box_flags_type               box_in,
   output logic                        valid_out,
   input  logic                        ready_down,
   output orient_set_type              orient_out,
   output box_flags_type               box_out
);

   // product stage
   logic                        mul_valid_ff;
   logic                        mul_ready;
   logic                        mul_load;
   logic signed [ProdWidth-1:0] lhs_ff [ORIENT_COUNT];
   logic signed [ProdWidth-1:0] rhs_ff [ORIENT_COUNT];
   logic signed [ProdWidth-1:0] lhs_in [ORIENT_COUNT];
   logic signed [ProdWidth-1:0] rhs_in [ORIENT_COUNT];
   box_flags_type               mul_box_ff;

   // compare stage
   logic                        cmp_valid_ff;
   logic                        cmp_ready;
   logic                        cmp_load;
   orient_type                  sign_in [ORIENT_COUNT];
   orient_set_type              orient_ff;
   orient_set_type              orient_in;
   box_flags_type               cmp_box_ff;

   function automatic logic signed [ProdWidth-1:0] mul(
      input logic signed [DiffWidth-1:0] a,
      input logic signed [DiffWidth-1:0] b
   );
      return ProdWidth'(a) * ProdWidth'(b);
   endfunction

   always_comb begin
      lhs_in[0] = mul(diff_in[DIFF_BAX], diff_in[DIFF_CAY]);
      rhs_in[0] = mul(diff_in[DIFF_BAY], diff_in[DIFF_CAX]);
      lhs_in[1] = mul(diff_in[DIFF_BAX], diff_in[DIFF_DAY]);
      rhs_in[1] = mul(diff_in[DIFF_BAY], diff_in[DIFF_DAX]);
      lhs_in[2] = mul(diff_in[DIFF_DCX], diff_in[DIFF_ACY]);
      rhs_in[2] = mul(diff_in[DIFF_DCY], diff_in[DIFF_ACX]);
      lhs_in[3] = mul(diff_in[DIFF_DCX], diff_in[DIFF_BCY]);
      rhs_in[3] = mul(diff_in[DIFF_DCY], diff_in[DIFF_BCX]);
   end

   always_comb begin
      for (int k = 0; k < ORIENT_COUNT; k++) begin
         if (lhs_ff[k] > rhs_ff[k]) begin
            sign_in[k] = ORIENT_POS;
         end else if (lhs_ff[k] < rhs_ff[k]) begin
            sign_in[k] = ORIENT_NEG;
         end else begin
            sign_in[k] = ORIENT_ZERO;
         end
      end
      orient_in.o1 = sign_in[0];
      orient_in.o2 = sign_in[1];
      orient_in.o3 = sign_in[2];
      orient_in.o4 = sign_in[3];
   end

   assign cmp_ready = !cmp_valid_ff || ready_down;
   assign cmp_load  = mul_valid_ff && cmp_ready;
   assign mul_ready = !mul_valid_ff || cmp_ready;
   assign mul_load  = valid_in && mul_ready;
   assign ready_up  = mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= valid_in;
         end
         if (cmp_ready) begin
            cmp_valid_ff <= mul_valid_ff;
         end
      end
      if (mul_load) begin
         lhs_ff     <= lhs_in;
         rhs_ff     <= rhs_in;
         mul_box_ff <= box_in;
      end
      if (cmp_load) begin
         orient_ff  <= orient_in;
         cmp_box_ff <= mul_box_ff;
      end
   end

   assign valid_out  = cmp_valid_ff;
   assign orient_out = orient_ff;
   assign box_out    = cmp_box_ff;

   // equal products must come out as a zero orientation
   `ASSERT_NEXT(equal_products_zero,
      cmp_load && (lhs_ff[0] == rhs_ff[0]),
      orient_ff.o1 == ORIENT_ZERO)

endmodule

// ===== rtl/core/segx_hit_stage.sv =====
// last stage: combines orientation signs and box checks into the result
// depends on segx_pkg and assert_macros.svh
`include "assert_macros.svh"

module segx_hit_stage
   import segx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           valid_in,
   output logic           ready_up,
   input  orient_set_type orient_in,
   input  box_flags_type  box_in,
   output logic           valid_out,
   input  logic           ready_down,
   output logic           intersects
);

   logic valid_ff;
   logic hit_ff;
   logic hit_in;
   logic proper;
   logic touch;
   logic load;

   always_comb begin
      proper = (orient_in.o1 != ORIENT_ZERO) && (orient_in.o2 != ORIENT_ZERO)
            && (orient_in.o3 != ORIENT_ZERO) && (orient_in.o4 != ORIENT_ZERO)
            && (orient_in.o1 != orient_in.o2) && (orient_in.o3 != orient_in.o4);
      touch  = ((orient_in.o1 == ORIENT_ZERO) && box_in.c_in_ab)
            || ((orient_in.o2 == ORIENT_ZERO) && box_in.d_in_ab)
            || ((orient_in.o3 == ORIENT_ZERO) && box_in.a_in_cd)
            || ((orient_in.o4 == ORIENT_ZERO) && box_in.b_in_cd);
      hit_in = proper || touch;
   end

   assign ready_up = !valid_ff || ready_down;
   assign load     = valid_in && ready_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_in;
      end
      if (load) begin
         hit_ff <= hit_in;
      end
   end

   assign valid_out  = valid_ff;
   assign intersects = hit_ff;

   // a zero orientation with the point in the box is a touch
   `ASSERT_NEXT(touch_reported,
      load && (orient_in.o1 == ORIENT_ZERO) && box_in.c_in_ab,
      hit_ff)

   // a strict crossing is always reported
   `ASSERT_NEXT(crossing_reported,
      load && (orient_in.o1 == ORIENT_POS) && (orient_in.o2 == ORIENT_NEG)
         && (orient_in.o3 == ORIENT_NEG) && (orient_in.o4 == ORIENT_POS),
      hit_ff)

endmodule

// ===== rtl/core/segment_intersection_test_top.sv =====
// a result passes the difference, product, compare and decision registers before it is offered
// throughput: one segment pair per cycle unless the response channel stalls; the four register stages
// (differences, cross products, sign compare, decision) each advancing on its own
// reset clears the stage valid bits only; no clearing pass, ready right after reset
// depends on segx_pkg, segx_req_if, segx_rsp_if and the three stage modules
module segment_intersection_test_top
   import segx_pkg::*;
#(
   parameter int COORD_WIDTH = 31
) (
   input  logic       clock,
   input  logic       reset,
   segx_req_if.sink   req_chan,
   segx_rsp_if.source rsp_chan
);

   localparam int DiffWidth = COORD_WIDTH + 1;

   logic                        diff_valid;
   logic                        diff_ready;
   logic signed [DiffWidth-1:0] diff_data [DIFF_COUNT];
   box_flags_type               diff_box;

   logic                        orient_valid;
   logic                        orient_ready;
   orient_set_type              orient_data;
   box_flags_type               orient_box;

   segx_diff_stage #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_diff (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (req_chan.valid),
      .ready_up   (req_chan.ready),
      .ax         (req_chan.seg1_ax),
      .ay         (req_chan.seg1_ay),
      .bx         (req_chan.seg1_bx),
      .by         (req_chan.seg1_by),
      .cx         (req_chan.seg2_ax),
      .cy         (req_chan.seg2_ay),
      .dx         (req_chan.seg2_bx),
      .dy         (req_chan.seg2_by),
      .valid_out  (diff_valid),
      .ready_down (diff_ready),
      .diff_out   (diff_data),
      .box_out    (diff_box)
   );

   segx_orient_stage #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_orient (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (diff_valid),
      .ready_up   (diff_ready),
      .diff_in    (diff_data),
      .box_in     (diff_box),
      .valid_out  (orient_valid),
      .ready_down (orient_ready),
      .orient_out (orient_data),
      .box_out    (orient_box)
   );

   segx_hit_stage u_hit (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (orient_valid),
      .ready_up   (orient_ready),
      .orient_in  (orient_data),
      .box_in     (orient_box),
      .valid_out  (rsp_chan.valid),
      .ready_down (rsp_chan.ready),
      .intersects (rsp_chan.intersects)
   );

endmodule
